// ----- sv/salwc_pkg.sv -----
// package for the set-associative write-back cache tag core
// types, defaults and command codes; no dependencies
`default_nettype none
package salwc_pkg;
  localparam int unsigned SETS_DEF      = 256;
  localparam int unsigned WAYS_DEF      = 8;
  localparam int unsigned ADDR_BITS_DEF = 48;
  localparam logic [2:0]  RANK_MAX      = 3'd7;

  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_PREFETCH = 2'd2,
    CMD_PROBE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_BLOCK_SHIFT = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- sv/set_assoc_lru_writeback_cache_core.sv -----
// Tag-only set-associative write-back cache with age-rank LRU replacement and
// eight wrapping 32-bit statistics counters. One set (all ways: tag, valid,
// dirty, rank) is one word of a single-port ram; a request reads the set in
// the cycle it is accepted, the lookup runs in ST_LOOKUP, and the update is
// written back and the result registered once no earlier result is stalled.
// A new request is taken while the result waits, but its write-back holds
// until the waiting result has left. After reset a clearing pass writes every
// set once, during which no request is accepted.
// depends on salwc_pkg and salwc_ram
`default_nettype none
module set_assoc_lru_writeback_cache_core #(
  parameter int unsigned SETS      = salwc_pkg::SETS_DEF,
  parameter int unsigned WAYS      = salwc_pkg::WAYS_DEF,
  parameter int unsigned ADDR_BITS = salwc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_cmd,
  input  wire logic [ADDR_BITS-1:0] in_address,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_hit,
  output logic [2:0]                out_way,
  output logic                      out_evicted,
  output logic                      out_wrote_back,
  output logic [31:0]               out_read_count,
  output logic [31:0]               out_write_count,
  output logic [31:0]               out_read_miss_count,
  output logic [31:0]               out_write_miss_count,
  output logic [31:0]               out_writeback_count,
  output logic [31:0]               out_eviction_count,
  output logic [31:0]               out_prefetch_count,
  output logic [31:0]               out_prefetch_miss_count,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [3:0]           cfg_data
);
  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned MAXIB  = $clog2(SETS + 1) - 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ENT_W  = ADDR_BITS + 5;
  localparam int unsigned WORD_W = ENT_W * WAYS;
  localparam int unsigned CNT_W  = $clog2(WAYS + 1);

  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic                 dirty;
    logic                 valid;
    logic [2:0]           rank;
  } entry_t;

  // configuration
  logic [3:0] block_shift_r, index_bits_r, ways_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r <= 4'd6;
      index_bits_r  <= 4'd8;
      ways_r        <= 4'd8;
    end else if (cfg_valid) begin
      unique case (salwc_pkg::cfg_idx_t'(cfg_index))
        salwc_pkg::CFG_BLOCK_SHIFT: block_shift_r <= cfg_data;
        salwc_pkg::CFG_INDEX_BITS:  index_bits_r  <= cfg_data;
        salwc_pkg::CFG_WAYS_IN_USE: ways_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // control
  salwc_pkg::state_t state_r, state_nxt;
  logic                 clr_r, clr_nxt;
  logic [SET_W:0]       clr_cnt_r, clr_cnt_nxt;
  logic [1:0]           cmd_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [SET_W-1:0]     set_r;
  logic                 out_valid_r;
  logic                 accept, out_take;

  logic [ADDR_BITS-1:0] tag_in;
  logic [3:0]           ib_sat;
  logic [SET_W-1:0]     set_in;

  always_comb begin
    tag_in = in_address >> block_shift_r;
    ib_sat = (32'(index_bits_r) > MAXIB) ? 4'(MAXIB) : index_bits_r;
    set_in = SET_W'(tag_in & ((ADDR_BITS'(1) << ib_sat) - ADDR_BITS'(1)));
  end

  // ram
  logic              ram_we;
  logic [SET_W-1:0]  ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  salwc_ram #(.WIDTH(WORD_W), .DEPTH(SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // lookup
  entry_t            ent   [WAYS];
  entry_t            upd   [WAYS];
  logic [CNT_W-1:0]  nways;
  logic              hit;
  logic [WAY_W-1:0]  hit_w, inv_w, vic_w, w;
  logic              inv_found, evict, wb;
  logic [2:0]        best;
  logic [2:0]        old_rank;
  logic              was_valid;
  logic              do_upd;

  always_comb begin
    nways = (ways_r == 4'd0) ? CNT_W'(1) :
            (32'(ways_r) > WAYS) ? CNT_W'(WAYS) : CNT_W'(ways_r);
    for (int j = 0; j < WAYS; j++) begin
      ent[j] = entry_t'(ram_rdata[j*ENT_W +: ENT_W]);
    end
    hit = 1'b0; hit_w = '0;
    inv_found = 1'b0; inv_w = '0;
    best = 3'd0; vic_w = '0;
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (32'(j) < 32'(nways)) begin
        if (ent[j].valid && ent[j].tag == tag_r) begin
          hit = 1'b1; hit_w = WAY_W'(j);
        end
        if (!ent[j].valid) begin
          inv_found = 1'b1; inv_w = WAY_W'(j);
        end
      end
    end
    for (int j = 0; j < WAYS; j++) begin
      if (32'(j) < 32'(nways) && ent[j].rank > best) begin
        best = ent[j].rank; vic_w = WAY_W'(j);
      end
    end
    do_upd = (cmd_r != salwc_pkg::CMD_PROBE);
    w      = hit ? hit_w : (inv_found ? inv_w : vic_w);
    evict  = do_upd && !hit && !inv_found;
    wb     = evict && ent[vic_w].dirty;
    was_valid = ent[w].valid;
    old_rank  = ent[w].rank;
    for (int j = 0; j < WAYS; j++) begin
      upd[j] = ent[j];
      if (32'(j) < 32'(nways) && WAY_W'(j) != w && ent[j].valid &&
          (!was_valid || ent[j].rank < old_rank) && ent[j].rank < salwc_pkg::RANK_MAX) begin
        upd[j].rank = ent[j].rank + 3'd1;
      end
    end
    upd[w].rank = 3'd0;
    if (hit) begin
      if (cmd_r == salwc_pkg::CMD_WRITE) upd[w].dirty = 1'b1;
    end else begin
      upd[w].tag   = tag_r;
      upd[w].valid = 1'b1;
      upd[w].dirty = (cmd_r == salwc_pkg::CMD_WRITE);
    end
  end

  // counters and result registers
  logic [31:0] cnt_r [8];
  logic        hit_r, evict_r, wb_r;
  logic [2:0]  way_r;

  assign out_take = out_valid_r && !out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    clr_cnt_nxt = clr_cnt_r;
    in_stall    = 1'b1;
    ram_we      = 1'b0;
    ram_addr    = set_in;
    ram_wdata   = '0;
    if (clr_r) begin
      ram_we   = 1'b1;
      ram_addr = clr_cnt_r[SET_W-1:0];
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (32'(clr_cnt_r) == SETS - 1) clr_nxt = 1'b0;
    end else begin
      unique case (state_r)
        salwc_pkg::ST_IDLE: begin
          in_stall = 1'b0;
          if (in_valid) state_nxt = salwc_pkg::ST_LOOKUP;
        end
        salwc_pkg::ST_LOOKUP: begin
          ram_addr = set_r;
          if (!out_valid_r || out_stall == 1'b0) begin
            ram_we = do_upd;
            for (int j = 0; j < WAYS; j++) begin
              ram_wdata[j*ENT_W +: ENT_W] = upd[j];
            end
            state_nxt = salwc_pkg::ST_IDLE;
          end
        end
        default: state_nxt = salwc_pkg::ST_IDLE;
      endcase
    end
  end

  logic lookup_done;
  assign lookup_done = !clr_r && state_r == salwc_pkg::ST_LOOKUP &&
                       (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= salwc_pkg::ST_IDLE;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) cnt_r[i] <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      if (lookup_done) begin
        out_valid_r <= 1'b1;
        if (do_upd) begin
          unique case (salwc_pkg::cmd_t'(cmd_r))
            salwc_pkg::CMD_READ: begin
              cnt_r[0] <= cnt_r[0] + 32'd1;
              if (!hit) cnt_r[2] <= cnt_r[2] + 32'd1;
            end
            salwc_pkg::CMD_WRITE: begin
              cnt_r[1] <= cnt_r[1] + 32'd1;
              if (!hit) cnt_r[3] <= cnt_r[3] + 32'd1;
            end
            default: begin
              cnt_r[6] <= cnt_r[6] + 32'd1;
              if (!hit) cnt_r[7] <= cnt_r[7] + 32'd1;
            end
          endcase
          if (evict) cnt_r[5] <= cnt_r[5] + 32'd1;
          if (wb)    cnt_r[4] <= cnt_r[4] + 32'd1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      tag_r <= tag_in;
      set_r <= set_in;
    end
    if (lookup_done) begin
      hit_r   <= hit;
      way_r   <= (!do_upd && !hit) ? 3'd0 : 3'(w);
      evict_r <= evict;
      wb_r    <= wb;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_hit                 = hit_r;
  assign out_way                 = way_r;
  assign out_evicted             = evict_r;
  assign out_wrote_back          = wb_r;
  assign out_read_count          = cnt_r[0];
  assign out_write_count         = cnt_r[1];
  assign out_read_miss_count     = cnt_r[2];
  assign out_write_miss_count    = cnt_r[3];
  assign out_writeback_count     = cnt_r[4];
  assign out_eviction_count      = cnt_r[5];
  assign out_prefetch_count      = cnt_r[6];
  assign out_prefetch_miss_count = cnt_r[7];

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> in_stall) else $error("request taken during clearing pass");
  a_lookup_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == salwc_pkg::ST_LOOKUP) else $error("lookup missed");
  a_wb_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wrote_back |-> out_evicted) else $error("writeback without eviction");
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit) else $error("eviction on hit");
`endif
endmodule
`default_nettype wire

// ----- sv/salwc_ram.sv -----
// generic single-port synchronous ram, registered read
// no dependencies
`default_nettype none
module salwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
